>>> src/bcc_pkg.sv
// ----------------------------------------------------------------------------
// bcc_pkg
// shared types, constants and modular arithmetic for the composition counter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bcc_pkg;

  localparam int COUNT_W = 30;
  localparam int STEPS_W = 10;
  localparam int PART_W  = 13;
  localparam int TARGET_W = 12;

  localparam logic [COUNT_W:0] MODULUS = 31'd1000000007;

  typedef struct packed {
    logic load;
    logic issue;
    logic first_round;
    logic last_item;
    logic set_zero;
    logic set_one;
    logic push;
  } bcc_cmd_t;

  function automatic logic [COUNT_W-1:0] mod_add(input logic [COUNT_W-1:0] a,
                                                 input logic [COUNT_W-1:0] b);
    logic [COUNT_W:0] s;
    logic [COUNT_W:0] r;
    s = {1'b0, a} + {1'b0, b};
    r = (s >= MODULUS) ? s - MODULUS : s;
    return r[COUNT_W-1:0];
  endfunction

  function automatic logic [COUNT_W-1:0] mod_sub(input logic [COUNT_W-1:0] a,
                                                 input logic [COUNT_W-1:0] b);
    logic [COUNT_W:0] r;
    if (a >= b) begin
      r = {1'b0, a} - {1'b0, b};
    end else begin
      r = {1'b0, a} + (MODULUS - {1'b0, b});
    end
    return r[COUNT_W-1:0];
  endfunction

endpackage

>>> src/bounded_composition_counter.sv
// ----------------------------------------------------------------------------
// bounded_composition_counter
// counts ordered compositions of a target into bounded parts, mod 1000000007
// ----------------------------------------------------------------------------
//  channel | handshake          | beat
//  --------+--------------------+--------------------------------
//  in      | in_valid, in_stall | steps, max_part, target
//  out     | out_valid,out_stall| count
//
//  a query runs n = min(steps, MAX_STEPS) rounds over entries 0..k, k = target,
//  one entry per cycle within a round, through the single-port-write row memories
//  queries with n = 0 or a target beyond the row skip the rounds
//  reset clears control state only, the row memories need no clearing
//  a finished count waits in the output register under out_stall
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bounded_composition_counter
  import bcc_pkg::*;
#(
  parameter int MAX_ROW   = 4096,
  parameter int MAX_STEPS = 512
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [STEPS_W-1:0]  steps,
  input  logic [PART_W-1:0]   max_part,
  input  logic [TARGET_W-1:0] target,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [COUNT_W-1:0]  count
);

  bcc_cmd_t                   cmd;
  logic [$clog2(MAX_ROW)-1:0] idx;

  bcc_ctrl #(.MAX_ROW(MAX_ROW), .MAX_STEPS(MAX_STEPS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .steps     (steps),
    .target    (target),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .idx       (idx)
  );

  bcc_datapath #(.MAX_ROW(MAX_ROW)) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .idx      (idx),
    .max_part (max_part),
    .count    (count)
  );

endmodule

>>> src/bcc_ram.sv
// ----------------------------------------------------------------------------
// bcc_ram
// simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcc_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/bcc_datapath.sv
// ----------------------------------------------------------------------------
// bcc_datapath
// row memories, running prefix and modular update, one entry per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcc_datapath
  import bcc_pkg::*;
#(
  parameter int MAX_ROW = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  bcc_cmd_t                   cmd,
  input  logic [$clog2(MAX_ROW)-1:0] idx,
  input  logic [PART_W-1:0]          max_part,
  output logic [COUNT_W-1:0]         count
);

  localparam int IDX_W = $clog2(MAX_ROW);
  localparam int CW = ((IDX_W > PART_W) ? IDX_W : PART_W) + 1;

  logic [PART_W-1:0]  d;
  logic               d_zero;
  logic [CW-1:0]      idx_w;
  logic [CW-1:0]      d_w;
  logic [CW-1:0]      back_w;
  logic               sub_ok;

  logic               p_valid;
  logic [IDX_W-1:0]   p_idx;
  logic               p_sub;
  logic               p_first;
  logic               p_last;

  logic [COUNT_W-1:0] vals_rdata;
  logic [COUNT_W-1:0] pre_rdata;
  logic [COUNT_W-1:0] pacc;
  logic [COUNT_W-1:0] prev;
  logic [COUNT_W-1:0] old_val;
  logic [COUNT_W-1:0] subtrahend;
  logic [COUNT_W-1:0] pre_next;
  logic [COUNT_W-1:0] val_next;
  logic [COUNT_W-1:0] result;

  assign idx_w  = CW'(idx);
  assign d_w    = CW'(d);
  assign sub_ok = idx_w >= d_w + CW'(1);
  assign back_w = idx_w - d_w - CW'(1);

  // first round sees the initial row: a one at entry 0
  always_comb begin
    prev       = (p_idx == '0) ? '0 : pacc;
    old_val    = p_first ? ((p_idx == '0) ? COUNT_W'(1) : '0) : vals_rdata;
    subtrahend = p_sub ? pre_rdata : '0;
    pre_next   = mod_add(prev, old_val);
    val_next   = d_zero ? '0 : mod_sub(prev, subtrahend);
  end

  bcc_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_ROW)) u_values (
    .clk   (clk),
    .we    (p_valid),
    .waddr (p_idx),
    .wdata (val_next),
    .raddr (idx),
    .rdata (vals_rdata)
  );

  bcc_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_ROW)) u_prefix (
    .clk   (clk),
    .we    (p_valid),
    .waddr (p_idx),
    .wdata (pre_next),
    .raddr (back_w[IDX_W-1:0]),
    .rdata (pre_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= cmd.issue;
    end
    if (cmd.load) begin
      d      <= max_part;
      d_zero <= (max_part == '0);
    end
    p_idx   <= idx;
    p_sub   <= sub_ok;
    p_first <= cmd.first_round;
    p_last  <= cmd.last_item;
    if (p_valid) begin
      pacc <= pre_next;
    end
    if (cmd.set_zero) begin
      result <= '0;
    end else if (cmd.set_one) begin
      result <= COUNT_W'(1);
    end else if (p_valid && p_last) begin
      result <= val_next;
    end
    if (cmd.push) begin
      count <= result;
    end
  end

endmodule

>>> src/bcc_ctrl.sv
// ----------------------------------------------------------------------------
// bcc_ctrl
// query sequencer: entry and round counters, handshakes, result hand-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcc_ctrl
  import bcc_pkg::*;
#(
  parameter int MAX_ROW   = 4096,
  parameter int MAX_STEPS = 512
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [STEPS_W-1:0]         steps,
  input  logic [TARGET_W-1:0]        target,
  output logic                       out_valid,
  input  logic                       out_stall,
  output bcc_cmd_t                   cmd,
  output logic [$clog2(MAX_ROW)-1:0] idx
);

  localparam int IDX_W = $clog2(MAX_ROW);
  localparam int RW = $clog2(MAX_STEPS + 1);

  typedef enum logic [1:0] {
    IDLE,
    RUN,
    DRAIN,
    PUSH
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] i;
  logic [IDX_W-1:0] k;
  logic [RW-1:0]    round;
  logic [RW-1:0]    n;

  logic             accept;
  logic             last_round;
  logic             slot_free;
  logic [31:0]      steps_w;
  logic [31:0]      n_sat;
  logic [31:0]      target_w;
  logic             k_big;

  assign accept     = in_valid && (state == IDLE);
  assign in_stall   = (state != IDLE);
  assign last_round = (round == n - RW'(1));
  assign slot_free  = !out_valid || !out_stall;
  assign steps_w    = 32'(steps);
  assign n_sat      = (steps_w > 32'(MAX_STEPS)) ? 32'(MAX_STEPS) : steps_w;
  assign target_w   = 32'(target);
  assign k_big      = target_w >= 32'(MAX_ROW);
  assign idx        = i;

  always_comb begin
    cmd             = '0;
    cmd.load        = accept;
    cmd.set_zero    = accept && (k_big || ((n_sat == 0) && (target != '0)));
    cmd.set_one     = accept && !k_big && (n_sat == 0) && (target == '0);
    cmd.issue       = (state == RUN);
    cmd.first_round = (round == '0);
    cmd.last_item   = (state == RUN) && last_round && (i == k);
    cmd.push        = (state == PUSH) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      i         <= '0;
      round     <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (accept) begin
            n     <= n_sat[RW-1:0];
            k     <= target_w[IDX_W-1:0];
            i     <= '0;
            round <= '0;
            if (k_big || (n_sat == 0)) begin
              state <= PUSH;
            end else begin
              state <= RUN;
            end
          end
        end
        RUN: begin
          if (i == k) begin
            state <= DRAIN;
          end else begin
            i <= i + IDX_W'(1);
          end
        end
        DRAIN: begin
          i <= '0;
          if (last_round) begin
            state <= PUSH;
          end else begin
            round <= round + RW'(1);
            state <= RUN;
          end
        end
        PUSH: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            state     <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the bounded composition counter: each accepted
// query is scored by a behavioural prefix-sum model held in the bench, and
// every returned count is compared in order against it. directed queries
// cover the corner cases, then random queries run with random idling on
// both channels; one long output hold-off run before them backs up the input
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import bcc_pkg::*;

  localparam int ROW_DEPTH    = 4096;
  localparam int STEP_CAP     = 512;
  localparam longint unsigned COUNT_PRIME = 64'd1000000007;
  localparam int CYCLE_LIMIT  = 4000000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_QUERIES = 70;

  typedef struct {
    logic [STEPS_W-1:0]  steps;
    logic [PART_W-1:0]   max_part;
    logic [TARGET_W-1:0] target;
    logic [COUNT_W-1:0]  count;
  } pending_query_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [STEPS_W-1:0]  steps;
  logic [PART_W-1:0]   max_part;
  logic [TARGET_W-1:0] target;
  logic                out_valid;
  logic                out_stall;
  logic [COUNT_W-1:0]  count;

  pending_query_t pending_counts[$];
  logic [COUNT_W-1:0] comp_row [0:ROW_DEPTH-1];
  logic [COUNT_W-1:0] comp_prefix [0:ROW_DEPTH-1];

  int  error_count = 0;
  int  cycle_count = 0;
  int  hold_request = 0;
  bit  tx_steady = 1'b0;
  bit  rx_steady = 1'b0;

  bounded_composition_counter #(
    .MAX_ROW   (ROW_DEPTH),
    .MAX_STEPS (STEP_CAP)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .steps     (steps),
    .max_part  (max_part),
    .target    (target),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .count     (count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d counts outstanding", cycle_count,
             pending_counts.size());
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [COUNT_W-1:0] residue_add(input logic [COUNT_W-1:0] a,
                                                     input logic [COUNT_W-1:0] b);
    longint unsigned s;
    s = longint'(a) + longint'(b);
    if (s >= COUNT_PRIME) begin
      s = s - COUNT_PRIME;
    end
    return s[COUNT_W-1:0];
  endfunction

  function automatic logic [COUNT_W-1:0] residue_sub(input logic [COUNT_W-1:0] a,
                                                     input logic [COUNT_W-1:0] b);
    longint unsigned s;
    if (a >= b) begin
      s = longint'(a) - longint'(b);
    end else begin
      s = longint'(a) + (COUNT_PRIME - longint'(b));
    end
    return s[COUNT_W-1:0];
  endfunction

  // ways to reach tgt in n parts of 1..part, rebuilt from scratch per query
  function automatic logic [COUNT_W-1:0] count_compositions(
    input logic [STEPS_W-1:0]  n_raw,
    input logic [PART_W-1:0]   part,
    input logic [TARGET_W-1:0] tgt
  );
    int rounds;
    int k;
    int i;
    int r;
    logic [COUNT_W-1:0] v;
    rounds = (int'(n_raw) > STEP_CAP) ? STEP_CAP : int'(n_raw);
    k = int'(tgt);
    if (k >= ROW_DEPTH) begin
      return '0;
    end
    for (i = 0; i <= k; i++) begin
      comp_row[i]    = '0;
      comp_prefix[i] = '0;
    end
    comp_row[0] = COUNT_W'(1);
    for (r = 0; r < rounds; r++) begin
      comp_prefix[0] = comp_row[0];
      for (i = 1; i <= k; i++) begin
        comp_prefix[i] = residue_add(comp_row[i], comp_prefix[i-1]);
      end
      comp_row[0] = '0;
      for (i = 1; i <= k; i++) begin
        v = comp_prefix[i-1];
        if (i > int'(part)) begin
          v = residue_sub(v, comp_prefix[i-int'(part)-1]);
        end
        comp_row[i] = v;
      end
    end
    return comp_row[k];
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic send_query(input int n, input int d, input int k);
    int gap;
    pending_query_t q;
    gap = tx_steady ? 0 : $urandom_range(0, 16);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    steps    = n[STEPS_W-1:0];
    max_part = d[PART_W-1:0];
    target   = k[TARGET_W-1:0];
    do @(posedge clk); while (in_stall);
    q.steps    = steps;
    q.max_part = max_part;
    q.target   = target;
    q.count    = count_compositions(steps, max_part, target);
    pending_counts.push_back(q);
  endtask

  // output side: random stall per beat, plus a long hold-off on request
  initial begin : count_sink
    int hold;
    int gap_cycles;
    out_stall = 1'b1;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (hold_request > 0) begin
        hold = hold_request;
        hold_request = 0;
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
      end
      gap_cycles = rx_steady ? 0 : $urandom_range(0, 16);
      if (gap_cycles > 0) begin
        out_stall = 1'b1;
        repeat (gap_cycles) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid && hold_request == 0);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : count_check
    pending_query_t exp_q;
    if (!rst && out_valid && !out_stall) begin
      if (pending_counts.size() == 0) begin
        report_error($sformatf("count %0d with no query outstanding", count));
      end else begin
        exp_q = pending_counts.pop_front();
        if (count !== exp_q.count) begin
          report_error($sformatf("n=%0d d=%0d k=%0d: count %0d, expected %0d",
                                 exp_q.steps, exp_q.max_part, exp_q.target,
                                 count, exp_q.count));
        end
      end
    end
  end

  task automatic test_empty_queries;
    send_query(0, 1, 0);
    send_query(0, 5, 3);
    send_query(0, 0, 0);
    send_query(0, 8191, 4095);
  endtask

  task automatic test_zero_part;
    send_query(3, 0, 3);
    send_query(1, 0, 0);
    send_query(1, 0, 7);
  endtask

  task automatic test_small_counts;
    send_query(3, 2, 4);
    send_query(1, 1, 1);
    send_query(4, 3, 7);
    send_query(2, 6, 6);
  endtask

  task automatic test_large_parts;
    send_query(3, 8191, 5);
    send_query(3, 4096, 9);
  endtask

  task automatic test_step_saturation;
    send_query(1023, 1, 512);
    send_query(1023, 3, 5);
    send_query(513, 8191, 2);
  endtask

  task automatic test_wide_target;
    send_query(1, 4095, 4095);
    send_query(1, 4094, 4095);
    send_query(2, 2048, 4095);
    send_query(1, 2048, 2048);
  endtask

  task automatic test_modular_wrap;
    send_query(20, 8191, 40);
    send_query(40, 3, 80);
  endtask

  // hold the output long enough for the input side to back up
  task automatic test_output_backpressure;
    int idx;
    tx_steady = 1'b1;
    hold_request = 300;
    for (idx = 0; idx < 8; idx++) begin
      send_query($urandom_range(0, 2), $urandom_range(0, 4), $urandom_range(0, 6));
    end
    tx_steady = 1'b0;
  endtask

  task automatic test_random_queries;
    int idx;
    int shape;
    int n;
    int d;
    int k;
    for (idx = 0; idx < RANDOM_QUERIES; idx++) begin
      tx_steady = (idx >= 40 && idx < 60);
      rx_steady = (idx >= 40 && idx < 60);
      shape = $urandom_range(0, 19);
      if (shape < 12) begin
        n = $urandom_range(0, 24);
        k = $urandom_range(0, 40);
        d = shape[0] ? $urandom_range(0, k + 2) : $urandom_range(0, 8191);
      end else if (shape < 15) begin
        n = $urandom_range(0, 1023);
        k = $urandom_range(0, 3);
        d = $urandom_range(0, 8191);
      end else if (shape < 18) begin
        n = $urandom_range(0, 1);
        k = $urandom_range(0, 4095);
        d = $urandom_range(0, 8191);
      end else begin
        n = $urandom_range(0, 8);
        k = $urandom_range(0, 200);
        d = $urandom_range(0, 8191);
      end
      send_query(n, d, k);
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    steps    = '0;
    max_part = '0;
    target   = '0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    test_empty_queries();
    test_zero_part();
    test_small_counts();
    test_large_parts();
    test_step_saturation();
    test_wide_target();
    test_modular_wrap();
    test_output_backpressure();
    test_random_queries();

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
src/bcc_pkg.sv
src/bcc_ram.sv
src/bcc_datapath.sv
src/bcc_ctrl.sv
src/bounded_composition_counter.sv
tb/tb_top.sv
